@@ rtl/core/cmnta_pkg.sv @@
// shared constants, types and codes for the cube map nearest texel address block
// no dependencies
package cmnta_pkg;

    localparam int MAX_EXTENT      = 4096;
    localparam int MAX_DEPTH       = 16;
    localparam int COORD_FRAC_BITS = 14;

    localparam int DIV_BITS = 17;

    typedef enum logic [2:0] {
        CFG_CUBE_MODE  = 3'd0,
        CFG_WIDTH      = 3'd1,
        CFG_HEIGHT     = 3'd2,
        CFG_DEPTH      = 3'd3,
        CFG_COMPONENTS = 3'd4,
        CFG_IMAGE_SIZE = 3'd5
    } cfg_index_t;

    localparam logic [2:0] FACE_POS_X = 3'd0;
    localparam logic [2:0] FACE_NEG_X = 3'd1;
    localparam logic [2:0] FACE_POS_Y = 3'd2;
    localparam logic [2:0] FACE_NEG_Y = 3'd3;
    localparam logic [2:0] FACE_POS_Z = 3'd4;
    localparam logic [2:0] FACE_NEG_Z = 3'd5;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_ZERO_DIR = 2'd1;
    localparam logic [1:0] STATUS_OOB      = 2'd2;

    // per-item data that rides along the divider stages
    typedef struct packed {
        logic [2:0]  face;
        logic        zero_dir;
        logic        cube;
        logic [16:0] u_2d;
        logic [16:0] v_2d;
    } side_t;

endpackage

@@ rtl/core/cmnta_front.sv @@
// first stage: face selection, numerators and 2d coordinate conversion
// depends on cmnta_pkg
module cmnta_front
(
    input  logic                 clk,
    input  logic                 en,
    input  logic                 cube_mode,
    input  logic signed [15:0]   coord_x,
    input  logic signed [15:0]   coord_y,
    input  logic signed [15:0]   coord_z,
    output logic [17:0]          num_u_reg,
    output logic [17:0]          num_v_reg,
    output logic [16:0]          mag_reg,
    output cmnta_pkg::side_t     side_reg
);
    import cmnta_pkg::*;

    logic signed [17:0] sx, sy, sz, a, b, num_a, num_b;
    logic [16:0] ax, ay, az, m;
    logic [2:0]  face;
    logic [17:0] num_u_next, num_v_next;
    side_t       side_next;

    function automatic logic [16:0] to_q16(input logic signed [15:0] c);
        logic signed [31:0] v;
        logic [31:0]        s;
        begin
            v = 32'(c);
            if (v < 0)
                v = 0;
            if (v > (32'sd1 <<< COORD_FRAC_BITS))
                v = 32'sd1 <<< COORD_FRAC_BITS;
            if (COORD_FRAC_BITS <= 16)
                s = 32'(v) << (16 - COORD_FRAC_BITS);
            else
                s = 32'(v) >> (COORD_FRAC_BITS - 16);
            to_q16 = s[16:0];
        end
    endfunction

    always_comb
    begin
        sx = 18'(coord_x);
        sy = 18'(coord_y);
        sz = 18'(coord_z);
        ax = (sx < 0) ? 17'(-sx) : 17'(sx);
        ay = (sy < 0) ? 17'(-sy) : 17'(sy);
        az = (sz < 0) ? 17'(-sz) : 17'(sz);
        // ties go to z, then y
        if (az >= ax && az >= ay)
        begin
            m = az;
            if (sz < 0)
            begin
                face = FACE_NEG_Z; a = -sx; b = -sy;
            end
            else
            begin
                face = FACE_POS_Z; a = sx;  b = -sy;
            end
        end
        else if (ay >= ax)
        begin
            m = ay;
            if (sy < 0)
            begin
                face = FACE_NEG_Y; a = sx; b = -sz;
            end
            else
            begin
                face = FACE_POS_Y; a = sx; b = sz;
            end
        end
        else
        begin
            m = ax;
            if (sx < 0)
            begin
                face = FACE_NEG_X; a = sz;  b = -sy;
            end
            else
            begin
                face = FACE_POS_X; a = -sz; b = -sy;
            end
        end
        num_a = a + $signed({1'b0, m});
        num_b = b + $signed({1'b0, m});
        num_u_next = (num_a < 0) ? '0 : 18'(num_a);
        num_v_next = (num_b < 0) ? '0 : 18'(num_b);

        side_next.cube     = cube_mode;
        side_next.zero_dir = cube_mode && ax == '0 && ay == '0 && az == '0;
        side_next.face     = cube_mode ? face : FACE_POS_X;
        side_next.u_2d     = to_q16(coord_x);
        side_next.v_2d     = to_q16(coord_y);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_u_reg <= num_u_next;
            num_v_reg <= num_v_next;
            mag_reg   <= m;
            side_reg  <= side_next;
        end
    end

endmodule

@@ rtl/core/cmnta_div_step.sv @@
// one register stage of the restoring divider for (a+m)/(2m) in q1.16
// depends on cmnta_pkg
module cmnta_div_step
#(
    parameter int START  = 0,
    parameter int NSTEPS = 6
)
(
    input  logic        clk,
    input  logic        en,
    input  logic [17:0] rem_in,
    input  logic [16:0] quo_in,
    input  logic [16:0] mag_in,
    output logic [17:0] rem_reg,
    output logic [16:0] quo_reg,
    output logic [16:0] mag_reg
);
    import cmnta_pkg::*;

    logic [17:0] rem_next, trial;
    logic [16:0] quo_next;

    always_comb
    begin
        rem_next = rem_in;
        quo_next = quo_in;
        for (int k = 0; k < NSTEPS; k++)
        begin
            // first bit has weight 2, second weight 1, the rest shift in
            if (START + k == 0)
                trial = {mag_in, 1'b0};
            else if (START + k == 1)
                trial = {1'b0, mag_in};
            else
            begin
                rem_next = {rem_next[16:0], 1'b0};
                trial    = {1'b0, mag_in};
            end
            if (rem_next >= trial)
            begin
                rem_next = rem_next - trial;
                quo_next = {quo_next[DIV_BITS-2:0], 1'b1};
            end
            else
                quo_next = {quo_next[DIV_BITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            mag_reg <= mag_in;
        end
    end

endmodule

@@ rtl/core/cmnta_addr.sv @@
// back end: texel rounding, address products, sum and bounds check, output register
// depends on cmnta_pkg
module cmnta_addr
(
    input  logic              clk,
    input  logic [3:0]        en,
    input  cmnta_pkg::side_t  side,
    input  logic [16:0]       quo_u,
    input  logic [16:0]       quo_v,
    input  logic [12:0]       width_cfg,
    input  logic [12:0]       height_cfg,
    input  logic [4:0]        depth_cfg,
    input  logic [2:0]        comp_cfg,
    input  logic [32:0]       image_bytes_cfg,
    output logic [2:0]        face_reg,
    output logic [11:0]       texel_x_reg,
    output logic [11:0]       texel_y_reg,
    output logic [32:0]       byte_address_reg,
    output logic [1:0]        status_reg
);
    import cmnta_pkg::*;

    logic [12:0] w, h;
    logic [4:0]  d;
    logic [2:0]  c;
    logic [14:0] row_reg;
    logic [27:0] plane_reg;
    logic [32:0] stride_reg;

    logic [16:0] u16, v16;
    logic [29:0] prod_x, prod_y;
    logic [35:0] face_prod;
    logic [11:0] tx5_reg, ty5_reg;
    logic [32:0] face_off5_reg, face_off6_reg;
    logic [2:0]  face5_reg, face6_reg, face7_reg;
    logic        zero5_reg, zero6_reg, zero7_reg;
    logic [11:0] tx6_reg, ty6_reg, tx7_reg, ty7_reg;
    logic [26:0] prow6_reg;
    logic [14:0] pcol6_reg;
    logic [33:0] sum7;
    logic [32:0] addr7_reg;

    always_comb
    begin
        w = (width_cfg == '0) ? 13'd1
          : (width_cfg > 13'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : width_cfg;
        h = (height_cfg == '0) ? 13'd1
          : (height_cfg > 13'(MAX_EXTENT)) ? 13'(MAX_EXTENT) : height_cfg;
        d = (depth_cfg == '0) ? 5'd1
          : (depth_cfg > 5'(MAX_DEPTH)) ? 5'(MAX_DEPTH) : depth_cfg;
        c = (comp_cfg == '0) ? 3'd1 : (comp_cfg > 3'd4) ? 3'd4 : comp_cfg;
    end

    // face stride is registered through row_reg, plane_reg and stride_reg after a register write
    always_ff @(posedge clk)
    begin
        row_reg    <= 15'(w * c);
        plane_reg  <= 28'(row_reg * h);
        stride_reg <= 33'(plane_reg * d);
    end

    always_comb
    begin
        u16       = side.cube ? quo_u : side.u_2d;
        v16       = side.cube ? quo_v : side.v_2d;
        prod_x    = 30'(u16 * 12'(w - 13'd1)) + 30'd32768;
        prod_y    = 30'(v16 * 12'(h - 13'd1)) + 30'd32768;
        face_prod = 36'(side.face * stride_reg);
        sum7      = 34'(face_off6_reg) + 34'(prow6_reg) + 34'(pcol6_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            tx5_reg       <= prod_x[27:16];
            ty5_reg       <= prod_y[27:16];
            face_off5_reg <= face_prod[32:0];
            face5_reg     <= side.face;
            zero5_reg     <= side.zero_dir;
        end
        if (en[1])
        begin
            prow6_reg     <= 27'(ty5_reg * row_reg);
            pcol6_reg     <= 15'(tx5_reg * c);
            face_off6_reg <= face_off5_reg;
            face6_reg     <= face5_reg;
            zero6_reg     <= zero5_reg;
            tx6_reg       <= tx5_reg;
            ty6_reg       <= ty5_reg;
        end
        if (en[2])
        begin
            addr7_reg <= sum7[32:0];
            face7_reg <= face6_reg;
            zero7_reg <= zero6_reg;
            tx7_reg   <= tx6_reg;
            ty7_reg   <= ty6_reg;
        end
        if (en[3])
        begin
            if (zero7_reg)
            begin
                face_reg         <= '0;
                texel_x_reg      <= '0;
                texel_y_reg      <= '0;
                byte_address_reg <= '0;
                status_reg       <= STATUS_ZERO_DIR;
            end
            else
            begin
                face_reg         <= face7_reg;
                texel_x_reg      <= tx7_reg;
                texel_y_reg      <= ty7_reg;
                byte_address_reg <= addr7_reg;
                status_reg       <= (addr7_reg >= image_bytes_cfg) ? STATUS_OOB : STATUS_OK;
            end
        end
    end

endmodule

@@ rtl/core/cubemap_nearest_texel_address.sv @@
// top level: stream ports, configuration registers, pipeline control
// depends on cmnta_pkg, cmnta_front, cmnta_div_step, cmnta_addr
//
// Eight-stage pipeline taking one item per clock while the output is not stalled.
// Stage one picks the face, three stages run the 17-bit restoring division for u
// and v (six, six and five quotient bits), then texel rounding, address products,
// the address sum, and the output register with the bounds check. A stall backs
// up stage by stage; tready drops only when every stage holds an item. The face
// stride is recomputed through row_reg, plane_reg and stride_reg after a register
// write, before an item accepted after the write reaches the address stages.
module cubemap_nearest_texel_address
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // coord_x[15:0], coord_y[31:16], coord_z[47:32]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // face[2:0], texel_x[14:3], texel_y[26:15],
                                        // byte_address[59:27], status[61:60], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [32:0] cfg_data
);
    import cmnta_pkg::*;

    localparam int NSTAGE = 8;

    logic        cube_mode_reg;
    logic [12:0] width_reg, height_reg;
    logic [4:0]  depth_reg;
    logic [2:0]  comp_reg;
    logic [32:0] image_bytes_reg;

    logic [NSTAGE:1] valid_reg;
    logic [NSTAGE:1] rdy;

    logic [17:0] num_u1, num_v1, rem_u2, rem_v2, rem_u3, rem_v3, rem_u4, rem_v4;
    logic [16:0] mag1, mag_u2, mag_v2, mag_u3, mag_v3, mag_u4, mag_v4;
    logic [16:0] quo_u2, quo_v2, quo_u3, quo_v3, quo_u4, quo_v4;
    side_t       side1_reg, side2_reg, side3_reg, side4_reg;

    logic [2:0]  face;
    logic [11:0] texel_x, texel_y;
    logic [32:0] byte_address;
    logic [1:0]  status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cube_mode_reg   <= 1'b0;
            width_reg       <= 13'd1;
            height_reg      <= 13'd1;
            depth_reg       <= 5'd1;
            comp_reg        <= 3'd4;
            image_bytes_reg <= 33'd4;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CUBE_MODE:  cube_mode_reg   <= cfg_data[0];
                CFG_WIDTH:      width_reg       <= cfg_data[12:0];
                CFG_HEIGHT:     height_reg      <= cfg_data[12:0];
                CFG_DEPTH:      depth_reg       <= cfg_data[4:0];
                CFG_COMPONENTS: comp_reg        <= cfg_data[2:0];
                CFG_IMAGE_SIZE: image_bytes_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or the one after it moves
    always_comb
    begin
        rdy[NSTAGE] = !valid_reg[NSTAGE] || m_axis_tready;
        for (int i = NSTAGE - 1; i >= 1; i--)
            rdy[i] = !valid_reg[i] || rdy[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (rdy[1])
                valid_reg[1] <= s_axis_tvalid;
            for (int i = 2; i <= NSTAGE; i++)
                if (rdy[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    assign s_axis_tready = rdy[1];
    assign m_axis_tvalid = valid_reg[NSTAGE];

    cmnta_front u_front
    (
        .clk       (clk),
        .en        (rdy[1]),
        .cube_mode (cube_mode_reg),
        .coord_x   (s_axis_tdata[15:0]),
        .coord_y   (s_axis_tdata[31:16]),
        .coord_z   (s_axis_tdata[47:32]),
        .num_u_reg (num_u1),
        .num_v_reg (num_v1),
        .mag_reg   (mag1),
        .side_reg  (side1_reg)
    );

    cmnta_div_step #(.START(0),  .NSTEPS(6)) u_div_u2
        (.clk(clk), .en(rdy[2]), .rem_in(num_u1), .quo_in('0), .mag_in(mag1),
         .rem_reg(rem_u2), .quo_reg(quo_u2), .mag_reg(mag_u2));
    cmnta_div_step #(.START(0),  .NSTEPS(6)) u_div_v2
        (.clk(clk), .en(rdy[2]), .rem_in(num_v1), .quo_in('0), .mag_in(mag1),
         .rem_reg(rem_v2), .quo_reg(quo_v2), .mag_reg(mag_v2));
    cmnta_div_step #(.START(6),  .NSTEPS(6)) u_div_u3
        (.clk(clk), .en(rdy[3]), .rem_in(rem_u2), .quo_in(quo_u2), .mag_in(mag_u2),
         .rem_reg(rem_u3), .quo_reg(quo_u3), .mag_reg(mag_u3));
    cmnta_div_step #(.START(6),  .NSTEPS(6)) u_div_v3
        (.clk(clk), .en(rdy[3]), .rem_in(rem_v2), .quo_in(quo_v2), .mag_in(mag_v2),
         .rem_reg(rem_v3), .quo_reg(quo_v3), .mag_reg(mag_v3));
    cmnta_div_step #(.START(12), .NSTEPS(5)) u_div_u4
        (.clk(clk), .en(rdy[4]), .rem_in(rem_u3), .quo_in(quo_u3), .mag_in(mag_u3),
         .rem_reg(rem_u4), .quo_reg(quo_u4), .mag_reg(mag_u4));
    cmnta_div_step #(.START(12), .NSTEPS(5)) u_div_v4
        (.clk(clk), .en(rdy[4]), .rem_in(rem_v3), .quo_in(quo_v3), .mag_in(mag_v3),
         .rem_reg(rem_v4), .quo_reg(quo_v4), .mag_reg(mag_v4));

    always_ff @(posedge clk)
    begin
        if (rdy[2])
            side2_reg <= side1_reg;
        if (rdy[3])
            side3_reg <= side2_reg;
        if (rdy[4])
            side4_reg <= side3_reg;
    end

    cmnta_addr u_addr
    (
        .clk              (clk),
        .en               (rdy[8:5]),
        .side             (side4_reg),
        .quo_u            (quo_u4),
        .quo_v            (quo_v4),
        .width_cfg        (width_reg),
        .height_cfg       (height_reg),
        .depth_cfg        (depth_reg),
        .comp_cfg         (comp_reg),
        .image_bytes_cfg  (image_bytes_reg),
        .face_reg         (face),
        .texel_x_reg      (texel_x),
        .texel_y_reg      (texel_y),
        .byte_address_reg (byte_address),
        .status_reg       (status)
    );

    assign m_axis_tdata = {2'b00, status, byte_address, texel_y, texel_x, face};

`ifndef NO_ASSERTIONS
    a_zero_dir_clears: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && status == STATUS_ZERO_DIR |->
            face == '0 && texel_x == '0 && texel_y == '0 && byte_address == '0)
        else $error("zero direction item carries nonzero fields");

    a_face_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> face <= FACE_NEG_Z && status != 2'd3)
        else $error("face or status code out of range");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && (&valid_reg))
        else $error("input stalled while pipeline has room");
`endif

endmodule

@@ test/texel_address_checker.sv @@
// checker for the cube map nearest texel address block: mirrors register writes,
// predicts each result from accepted items and compares in order; depends on cmnta_pkg
`timescale 1ns / 1ps
module texel_address_checker
    import cmnta_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [32:0] cfg_data,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [32:0] addr;
        logic [11:0] ty;
        logic [11:0] tx;
        logic [2:0]  face;
    } lookup_t;

    logic        cube_r;
    logic [12:0] width_r;
    logic [12:0] height_r;
    logic [4:0]  depth_r;
    logic [2:0]  comp_r;
    logic [32:0] size_r;
    lookup_t     lookups_due[$];

    function automatic longint clampi(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint frac_q16(longint a, longint m);
        longint n;
        n = a + m;
        if (n < 0) n = 0;
        return (n * 65536) / (2 * m);
    endfunction

    function automatic lookup_t predict_lookup(logic [47:0] d);
        longint x, y, z, ax, ay, az, m, a, b, u, v, w, h, dp, c, tx, ty, row;
        logic [32:0] addr;
        lookup_t r;
        x = longint'($signed(d[15:0]));
        y = longint'($signed(d[31:16]));
        z = longint'($signed(d[47:32]));
        w = clampi(width_r, 1, MAX_EXTENT);
        h = clampi(height_r, 1, MAX_EXTENT);
        dp = clampi(depth_r, 1, MAX_DEPTH);
        c = clampi(comp_r, 1, 4);
        r = '0;
        r.face = FACE_POS_X;
        if (cube_r) begin
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            az = z < 0 ? -z : z;
            if (ax == 0 && ay == 0 && az == 0) begin
                r.status = STATUS_ZERO_DIR;
                return r;
            end
            if (az >= ax && az >= ay) begin
                m = az;
                if (z < 0) begin r.face = FACE_NEG_Z; a = -x; b = -y; end
                else begin r.face = FACE_POS_Z; a = x; b = -y; end
            end
            else if (ay >= ax) begin
                m = ay;
                if (y < 0) begin r.face = FACE_NEG_Y; a = x; b = -z; end
                else begin r.face = FACE_POS_Y; a = x; b = z; end
            end
            else begin
                m = ax;
                if (x < 0) begin r.face = FACE_NEG_X; a = z; b = -y; end
                else begin r.face = FACE_POS_X; a = -z; b = -y; end
            end
            u = frac_q16(a, m);
            v = frac_q16(b, m);
        end
        else begin
            u = clampi(x, 0, 1 << COORD_FRAC_BITS) << (16 - COORD_FRAC_BITS);
            v = clampi(y, 0, 1 << COORD_FRAC_BITS) << (16 - COORD_FRAC_BITS);
        end
        tx = (u * (w - 1) + 32768) >>> 16;
        ty = (v * (h - 1) + 32768) >>> 16;
        row = w * c;
        addr = 33'(longint'(r.face) * row * h * dp + ty * row + tx * c);
        r.tx = tx[11:0];
        r.ty = ty[11:0];
        r.addr = addr;
        r.status = (addr >= size_r) ? STATUS_OOB : STATUS_OK;
        return r;
    endfunction

    assign pending = lookups_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t got;
        lookup_t want;
        if (!rst_n)
        begin
            cube_r <= 1'b0;
            width_r <= 13'd1;
            height_r <= 13'd1;
            depth_r <= 5'd1;
            comp_r <= 3'd4;
            size_r <= 33'd4;
            fail_count <= 0;
            lookups_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index_t'(cfg_index))
                    CFG_CUBE_MODE:  cube_r <= cfg_data[0];
                    CFG_WIDTH:      width_r <= cfg_data[12:0];
                    CFG_HEIGHT:     height_r <= cfg_data[12:0];
                    CFG_DEPTH:      depth_r <= cfg_data[4:0];
                    CFG_COMPONENTS: comp_r <= cfg_data[2:0];
                    CFG_IMAGE_SIZE: size_r <= cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[61:0];
                if (lookups_due.size() == 0)
                begin
                    $error("result item with nothing expected: %h", m_axis_tdata);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = lookups_due.pop_front();
                    if (got != want || m_axis_tdata[63:62] != 2'b00)
                    begin
                        fail_count <= fail_count + 1;
                        if (got.face != want.face)
                            $error("face expected %0d got %0d", want.face, got.face);
                        if (got.tx != want.tx)
                            $error("texel_x expected %0d got %0d", want.tx, got.tx);
                        if (got.ty != want.ty)
                            $error("texel_y expected %0d got %0d", want.ty, got.ty);
                        if (got.addr != want.addr)
                            $error("byte_address expected %0d got %0d", want.addr, got.addr);
                        if (got.status != want.status)
                            $error("status expected %0d got %0d", want.status, got.status);
                        if (m_axis_tdata[63:62] != 2'b00)
                            $error("pad expected 0 got %0d", m_axis_tdata[63:62]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                lookups_due.push_back(predict_lookup(s_axis_tdata));
        end
    end

endmodule

@@ test/testbench.sv @@
// stimulus and verdict for cubemap_nearest_texel_address: register phases, directed and
// random lookups, bursty sender, stalling receiver; depends on cmnta_pkg, the block and the checker
`timescale 1ns / 1ps
module testbench;
    import cmnta_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [32:0] cfg_data;
    int          fail_count;
    int          pending;
    bit          hold_long;

    cubemap_nearest_texel_address uut (.*);

    texel_address_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("cubemap_nearest_texel_address verification failed");
        $finish;
    end

    // receiver stall pattern, plus one long hold-off when asked
    initial
    begin
        int mode;
        int n;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_long)
            begin
                m_axis_tready <= 1'b0;
                for (n = 0; n < 60; n++)
                    @(posedge clk);
                hold_long = 1'b0;
            end
            mode = $urandom_range(0, 3);
            for (n = $urandom_range(5, 40); n > 0; n--)
            begin
                // start the hold-off right away while the sender is still busy
                if (hold_long)
                    break;
                m_axis_tready <= (mode == 0) ? 1'b1 : ($urandom_range(0, mode) == 0);
                @(posedge clk);
            end
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [32:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        repeat (3) @(posedge clk);
    endtask

    task automatic drain_lookups;
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic send_lookup(logic [15:0] x, logic [15:0] y, logic [15:0] z, bit gap);
        if (gap && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {z, y, x};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic idle_input;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'h4000;
            2: return 16'hC000;
            3: return 16'(-$urandom_range(0, 17000));
            4: return 16'($urandom_range(0, 17000));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic setup_phase(int p);
        case (p)
            0: begin
                write_reg(CFG_CUBE_MODE, 33'd1);
                write_reg(CFG_WIDTH, 33'd4096);
                write_reg(CFG_HEIGHT, 33'd4096);
                write_reg(CFG_DEPTH, 33'd16);
                write_reg(CFG_COMPONENTS, 33'd4);
                write_reg(CFG_IMAGE_SIZE, 33'h1FFFFFFFF);
            end
            1: begin
                write_reg(CFG_CUBE_MODE, 33'd0);
                write_reg(CFG_WIDTH, 33'd1);
                write_reg(CFG_HEIGHT, 33'd1);
                write_reg(CFG_DEPTH, 33'd1);
                write_reg(CFG_COMPONENTS, 33'd1);
                write_reg(CFG_IMAGE_SIZE, 33'd0);
            end
            default: begin
                write_reg(CFG_CUBE_MODE, 33'($urandom_range(0, 1)));
                write_reg(CFG_WIDTH, 33'($urandom_range(0, 8191)));
                write_reg(CFG_HEIGHT, 33'($urandom_range(0, 8191)));
                write_reg(CFG_DEPTH, 33'($urandom_range(0, 31)));
                write_reg(CFG_COMPONENTS, 33'($urandom_range(0, 7)));
                write_reg(CFG_IMAGE_SIZE, {$urandom_range(0, 1), 32'($urandom)});
            end
        endcase
    endtask

    initial
    begin
        int p;
        int k;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        hold_long = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);
        // reset-state registers, then extreme cube settings with directed cases
        send_lookup(16'h4000, 16'h4000, 16'h0000, 0);
        idle_input();
        drain_lookups();
        setup_phase(0);
        send_lookup(16'h0000, 16'h0000, 16'h0000, 0);
        send_lookup(16'h4000, 16'h0000, 16'h0000, 0);
        send_lookup(16'hC000, 16'h0000, 16'h0000, 0);
        send_lookup(16'h0000, 16'h4000, 16'h0000, 0);
        send_lookup(16'h0000, 16'hC000, 16'h0000, 0);
        send_lookup(16'h0000, 16'h0000, 16'h4000, 0);
        send_lookup(16'h0000, 16'h0000, 16'hC000, 0);
        send_lookup(16'h4000, 16'h4000, 16'h4000, 0);
        send_lookup(16'h4000, 16'hC000, 16'h0000, 0);
        send_lookup(16'h8000, 16'h7FFF, 16'h8000, 0);
        send_lookup(16'h7FFF, 16'h8000, 16'h7FFF, 0);
        send_lookup(16'hFFFF, 16'h0001, 16'h0000, 0);
        send_lookup(16'h8000, 16'h8000, 16'h8000, 0);
        idle_input();
        drain_lookups();
        setup_phase(1);
        send_lookup(16'h8000, 16'h7FFF, 16'h1234, 0);
        idle_input();
        drain_lookups();
        write_reg(CFG_WIDTH, 33'd4096);
        write_reg(CFG_HEIGHT, 33'd3);
        write_reg(CFG_IMAGE_SIZE, 33'h1FFFFFFFF);
        send_lookup(16'h0000, 16'h0000, 16'h0000, 0);
        send_lookup(16'h4000, 16'h4000, 16'hFFFF, 0);
        send_lookup(16'h2000, 16'h2000, 16'h0000, 0);
        send_lookup(16'h4001, 16'hFFFF, 16'h0000, 0);
        send_lookup(16'h7FFF, 16'h8000, 16'h0000, 0);
        send_lookup(16'h0001, 16'h3FFF, 16'h0000, 0);
        // long receiver hold-off while the input keeps offering items
        hold_long = 1'b1;
        for (k = 0; k < 30; k++)
            send_lookup(pick_coord(), pick_coord(), pick_coord(), 0);
        idle_input();
        drain_lookups();
        for (p = 0; p < 14; p++)
        begin
            setup_phase(p < 2 ? p : 2);
            for (k = 0; k < 100; k++)
                send_lookup(pick_coord(), pick_coord(), pick_coord(), 1);
            idle_input();
            drain_lookups();
        end
        if (fail_count == 0)
            $display("cubemap_nearest_texel_address verification clean");
        else
            $display("cubemap_nearest_texel_address verification failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/cmnta_pkg.sv
rtl/core/cmnta_front.sv
rtl/core/cmnta_div_step.sv
rtl/core/cmnta_addr.sv
rtl/core/cubemap_nearest_texel_address.sv
test/texel_address_checker.sv
test/testbench.sv
